// File: src/assert_macros.svh
// Assertion macros used by the checker of the sorted list block.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A clocked property, disabled while reset is held.
`define SLI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A clocked same-cycle implication, disabled while reset is held.
`define SLI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: src/sli_pkg.sv
// Types and constants of the sorted list insert/delete block.
// Used by the memory, the controller, the top level, the checker and the testbench; depends on nothing.
`default_nettype none

package sli_pkg;

    localparam int DATA_W       = 32;
    localparam int COUNT_W      = 5;
    localparam int CAPACITY_DEF = 16;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic                     kind;
        logic signed [DATA_W-1:0] value;
    } op_t;

    typedef struct packed {
        status_t                  status;
        logic [COUNT_W-1:0]       count;
        logic signed [DATA_W-1:0] smallest;
        logic                     smallest_valid;
    } res_t;

endpackage

`default_nettype wire

// File: src/sli_mem.sv
// Entry storage: one write port and one read port with registered read data.
// Depends on sli_pkg for the data width and the default depth.
`default_nettype none

module sli_mem
    import sli_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEF,
    parameter int AW    = $clog2(CAPACITY_DEF)
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [AW-1:0]     raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: src/sli_ctrl.sv
// Sequencer that walks the entry memory one entry per cycle to insert or delete.
// Depends on sli_pkg; drives the ports of sli_mem.
`default_nettype none

module sli_ctrl
    import sli_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY_DEF),
    parameter int CW       = $clog2(CAPACITY_DEF + 1)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire op_t               op,
    output logic                   busy,
    output logic                   done,
    output res_t                   res,
    output logic                   mem_we,
    output logic      [AW-1:0]     mem_waddr,
    output logic      [DATA_W-1:0] mem_wdata,
    output logic      [AW-1:0]     mem_raddr,
    input  wire logic [DATA_W-1:0] mem_rdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_INS_TAIL,
        S_DEL
    } state_t;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic [AW-1:0]            idx_reg, idx_next;
    logic                     found_reg, found_next;
    logic signed [DATA_W-1:0] smallest_reg, smallest_next;
    logic                     done_reg;
    res_t                     res_reg, res_next;
    logic                     finish;
    status_t                  status_next;
    logic                     hit;

    // The insert walk writes entry idx+1 while reading idx-1, and the delete
    // walk writes idx-1 while reading idx+1, so a read never meets a write
    // to the same entry and no forwarding is needed.
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        val_next    = val_reg;
        idx_next    = idx_reg;
        found_next  = found_reg;
        finish      = 1'b0;
        status_next = ST_DONE;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_raddr   = idx_reg;
        hit         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    val_next = op.value;
                    if (op.kind == KIND_INSERT)
                    begin
                        if (cnt_reg == CW'(CAPACITY))
                        begin
                            finish      = 1'b1;
                            status_next = ST_FULL;
                        end
                        else if (cnt_reg == '0)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = '0;
                            mem_wdata = op.value;
                            cnt_next  = CW'(1);
                            finish    = 1'b1;
                        end
                        else
                        begin
                            mem_raddr  = AW'(cnt_reg - 1'b1);
                            idx_next   = AW'(cnt_reg - 1'b1);
                            state_next = S_INS;
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            finish      = 1'b1;
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            mem_raddr  = '0;
                            idx_next   = '0;
                            found_next = 1'b0;
                            state_next = S_DEL;
                        end
                    end
                end
            end

            S_INS:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg + 1'b1;
                if ($signed(mem_rdata) < val_reg)
                begin
                    mem_wdata  = val_reg;
                    cnt_next   = cnt_reg + 1'b1;
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    // Move the entry up one place and keep walking toward the front.
                    mem_wdata = mem_rdata;
                    if (idx_reg == '0)
                    begin
                        state_next = S_INS_TAIL;
                    end
                    else
                    begin
                        mem_raddr = idx_reg - 1'b1;
                        idx_next  = idx_reg - 1'b1;
                    end
                end
            end

            S_INS_TAIL:
            begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = val_reg;
                cnt_next   = cnt_reg + 1'b1;
                finish     = 1'b1;
                state_next = S_IDLE;
            end

            S_DEL:
            begin
                hit = !found_reg && (mem_rdata == $unsigned(val_reg));
                if (found_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg - 1'b1;
                    mem_wdata = mem_rdata;
                end
                found_next = found_reg || hit;
                if (idx_reg == AW'(cnt_reg - 1'b1))
                begin
                    finish     = 1'b1;
                    state_next = S_IDLE;
                    if (found_reg || hit)
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                end
                else
                begin
                    mem_raddr = idx_reg + 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // The front entry is mirrored in a register so every result can show it.
        if (mem_we && (mem_waddr == '0))
        begin
            smallest_next = $signed(mem_wdata);
        end
        else
        begin
            smallest_next = smallest_reg;
        end

        res_next.status         = status_next;
        res_next.count          = COUNT_W'(cnt_next);
        res_next.smallest_valid = (cnt_next != '0);
        res_next.smallest       = (cnt_next != '0) ? smallest_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            found_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            found_reg <= found_next;
            done_reg  <= finish;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        idx_reg      <= idx_next;
        smallest_reg <= smallest_next;
        if (finish)
        begin
            res_reg <= res_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

// File: src/sorted_list_insert_delete.sv
// Top level of the sorted list insert/delete block.
// Depends on sli_pkg, sli_mem and sli_ctrl.
//
// The block keeps up to CAPACITY signed values in ascending order in one
// memory with a registered read port, and a sequencer walks that memory.
// A transaction is accepted at a rising edge where start is high and busy
// is low; op carries the kind (insert or delete) and the value.
// Every transaction gives exactly one result on res, marked by done for
// one cycle; the receiver must take it then and cannot stall the block.
// An insert walks from the back down to the insert position, with an extra
// tail step when the value goes to the front; a delete scans and shifts the
// whole list. A full insert, an empty delete and an insert into an empty
// list finish without a walk. The memory moves one entry per cycle.
// busy drops in the cycle done is shown, so the next transaction can be
// accepted while the result is presented.
// Reset empties the list at once; no clearing pass is needed because only
// entries below the count are ever read.
`default_nettype none

module sorted_list_insert_delete
    import sli_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire op_t  op,
    output logic      busy,
    output logic      done,
    output res_t      res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    sli_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .op        (op),
        .busy      (busy),
        .done      (done),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    sli_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// File: src/sli_checker.sv
// Port-level checks for the sorted list block, bound to its top level.
// Depends on sli_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module sli_checker
    import sli_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire res_t res
);

    // An accepted transaction either starts a walk or answers at once.
    `SLI_ASSERT(a_accept_progress, (start && !busy) |=> (busy || done),
        "accepted transaction lost")

    // A result never appears without a transaction behind it.
    `SLI_ASSERT_IMP(a_done_has_cause, done, ($past(start && !busy) || $past(busy)),
        "spurious result")

    `SLI_ASSERT_IMP(a_valid_matches_count, done,
        (res.smallest_valid == (res.count != '0)), "smallest_valid disagrees with count")

    `SLI_ASSERT_IMP(a_empty_smallest_zero, (done && !res.smallest_valid),
        (res.smallest == '0), "smallest not zero on empty list")

    `SLI_ASSERT_IMP(a_status_count, done, ((res.status != ST_EMPTY) || (res.count == '0)),
        "empty status with stored values")

endmodule

bind sorted_list_insert_delete sli_checker u_sli_checker (.*);

`default_nettype wire

// File: verif/sorted_list_insert_delete_tb.sv
// Self-checking testbench for the sorted list insert/delete block.
// Depends on sli_pkg and sorted_list_insert_delete; a scoreboard class predicts each result.
`timescale 1ns / 1ps

// Keeps a mirror of the sorted table and the results it expects.
class sorted_table_scoreboard;
    logic signed [sli_pkg::DATA_W-1:0] entries[$];
    sli_pkg::res_t                     expected_results[$];
    int                                failures = 0;

    // Applies one transaction to the mirror and returns the result it should give.
    function sli_pkg::res_t apply_op(sli_pkg::op_t o);
        sli_pkg::res_t r;
        int            pos;
        pos = 0;
        r.status = sli_pkg::ST_DONE;
        if (o.kind == sli_pkg::KIND_INSERT)
        begin
            if (entries.size() >= sli_pkg::CAPACITY_DEF)
            begin
                r.status = sli_pkg::ST_FULL;
            end
            else
            begin
                while (pos < entries.size() && entries[pos] < o.value)
                    pos++;
                entries.insert(pos, o.value);
            end
        end
        else if (entries.size() == 0)
        begin
            r.status = sli_pkg::ST_EMPTY;
        end
        else
        begin
            while (pos < entries.size() && entries[pos] != o.value)
                pos++;
            if (pos >= entries.size())
                r.status = sli_pkg::ST_NOT_FOUND;
            else
                entries.delete(pos);
        end
        r.count = sli_pkg::COUNT_W'(entries.size());
        if (entries.size() > 0)
        begin
            r.smallest       = entries[0];
            r.smallest_valid = 1'b1;
        end
        else
        begin
            r.smallest       = '0;
            r.smallest_valid = 1'b0;
        end
        return r;
    endfunction

    function void note_op(sli_pkg::op_t o);
        expected_results.push_back(apply_op(o));
    endfunction

    function void check_result(sli_pkg::res_t got);
        sli_pkg::res_t exp;
        if (expected_results.size() == 0)
        begin
            $error("result with no transaction outstanding: %h", got);
            failures++;
            return;
        end
        exp = expected_results.pop_front();
        if (got.status !== exp.status)
        begin
            $error("status: expected %0d, actual %0d", exp.status, got.status);
            failures++;
        end
        if (got.count !== exp.count)
        begin
            $error("count: expected %0d, actual %0d", exp.count, got.count);
            failures++;
        end
        if (got.smallest !== exp.smallest)
        begin
            $error("smallest: expected %0d, actual %0d", exp.smallest, got.smallest);
            failures++;
        end
        if (got.smallest_valid !== exp.smallest_valid)
        begin
            $error("smallest_valid: expected %0b, actual %0b",
                   exp.smallest_valid, got.smallest_valid);
            failures++;
        end
    endfunction

    function int pending();
        return expected_results.size();
    endfunction
endclass

module sorted_list_insert_delete_tb;
    import sli_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    op_t  op    = '0;
    logic busy;
    logic done;
    res_t res;

    sorted_table_scoreboard table_sb = new();
    int  cycles  = 0;
    bit  no_idle = 1'b0;

    sorted_list_insert_delete dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .busy  (busy),
        .done  (done),
        .res   (res)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // The result of the previous transaction is checked before a new one is noted,
    // which keeps the queue in order when both happen at one edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                table_sb.check_result(res);
            if (start && !busy)
                table_sb.note_op(op);
        end
    end

    // Presents one transaction and returns at the edge that accepts it.
    task automatic send_op(logic kind, logic signed [DATA_W-1:0] value);
        op_t o;
        o.kind  = kind;
        o.value = value;
        while (!no_idle && $urandom_range(99) < 12)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        op    <= o;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Small values in 35 of 100 picks so that duplicates and delete hits are common.
    function automatic logic signed [DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 35)
            return $signed($urandom_range(8)) - 4;
        else if (sel < 45)
            return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        else
            return $urandom;
    endfunction

    initial
    begin
        int  fill_bias;
        bit  is_insert;
        logic signed [DATA_W-1:0] v;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty delete, removing the only entry, extremes, absent value,
        // filling to capacity and a dropped insert.
        send_op(KIND_DELETE, 32'sd9);
        send_op(KIND_INSERT, 32'sd5);
        send_op(KIND_DELETE, 32'sd5);
        send_op(KIND_INSERT, 32'sh7FFF_FFFF);
        send_op(KIND_INSERT, 32'sh8000_0000);
        send_op(KIND_INSERT, 32'sd0);
        send_op(KIND_INSERT, -32'sd1);
        send_op(KIND_INSERT, 32'sd1);
        send_op(KIND_DELETE, 32'sd7);
        send_op(KIND_INSERT, 32'sd0);
        repeat (10) send_op(KIND_INSERT, pick_value());
        send_op(KIND_INSERT, 32'sd3);
        send_op(KIND_INSERT, 32'sd2);
        send_op(KIND_DELETE, 32'sh8000_0000);
        send_op(KIND_DELETE, 32'sh7FFF_FFFF);
        send_op(KIND_DELETE, 32'sd0);

        // Random: alternating fill and drain phases walk the count from empty to full.
        fill_bias = 75;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_idle = (n >= 400 && n < 650);
            if (n % 40 == 0)
                fill_bias = 100 - fill_bias;
            is_insert = ($urandom_range(99) < fill_bias);
            if (!is_insert && table_sb.entries.size() > 0 && $urandom_range(99) < 65)
                v = table_sb.entries[$urandom_range(table_sb.entries.size() - 1)];
            else
                v = pick_value();
            send_op(is_insert ? KIND_INSERT : KIND_DELETE, v);
        end
        start <= 1'b0;

        while (table_sb.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (table_sb.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
